// ===== src/pts_pkg.sv =====
// shared types and constants of the periodic task tick scheduler
package pts_pkg;

    localparam int MAX_TASKS_DEF = 20;
    localparam int MODE_W        = 2;
    localparam int PERIOD_W      = 8;
    localparam int DELAY_W       = 16;
    localparam int IDX_OUT_W     = 5;
    localparam int CNT_OUT_W     = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_REGISTER = 2'd2,
        MODE_DELAY    = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic                pend;
        logic [PERIOD_W-1:0] countdown;
        logic [PERIOD_W-1:0] reload;
    } pts_entry_t;

    typedef struct packed {
        logic start_walk;
        logic walk_tick;
        logic dec_delay;
        logic walk;
        logic finish;
        logic do_register;
        logic load_delay;
    } pts_cmd_t;

    typedef struct packed {
        logic can_load;
        logic walk_done;
    } pts_status_t;

endpackage

// ===== src/pts_if.sv =====
// channel interfaces for scheduler items and results
interface pts_in_if import pts_pkg::*;;
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [PERIOD_W-1:0] period;
    logic [DELAY_W-1:0]  delay_count;

    modport source (output valid, output mode, output period, output delay_count,
                    input ready);
    modport sink (input valid, input mode, input period, input delay_count,
                  output ready);
endinterface

interface pts_out_if import pts_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [IDX_OUT_W-1:0] task_index;
    logic                 task_valid;
    logic                 status;
    logic                 delay_busy;
    logic [CNT_OUT_W-1:0] task_count;
    logic                 last;

    modport source (output valid, output task_index, output task_valid, output status,
                    output delay_busy, output task_count, output last, input ready);
    modport sink (input valid, input task_index, input task_valid, input status,
                  input delay_busy, input task_count, input last, output ready);
endinterface

// ===== src/pts_ram.sv =====
// generic single-write, single-read ram with registered read data
module pts_ram import pts_pkg::*; #(
    parameter int WIDTH = $bits(pts_entry_t),
    parameter int DEPTH = MAX_TASKS_DEF
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic                                      rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/pts_ctrl.sv =====
// controller state machine sequencing item acceptance, slot walks and final results
module pts_ctrl import pts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  mode_t       in_mode,
    output logic        in_ready,
    input  pts_status_t stat,
    output pts_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = stat.can_load;
                if (in_valid && stat.can_load)
                begin
                    case (in_mode)
                        MODE_TICK:
                        begin
                            cmd.start_walk = 1'b1;
                            cmd.walk_tick  = 1'b1;
                            cmd.dec_delay  = 1'b1;
                            state_next     = ST_WALK;
                        end
                        MODE_DISPATCH:
                        begin
                            cmd.start_walk = 1'b1;
                            state_next     = ST_WALK;
                        end
                        MODE_REGISTER:
                        begin
                            cmd.do_register = 1'b1;
                        end
                        MODE_DELAY:
                        begin
                            cmd.load_delay = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL:
            begin
                cmd.finish = 1'b1;
                if (stat.can_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pts_datapath.sv =====
// task table, slot walk pipeline, delay counter and result register
module pts_datapath import pts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pts_cmd_t            cmd,
    output pts_status_t         stat,
    input  logic [PERIOD_W-1:0] period,
    input  logic [DELAY_W-1:0]  delay_count,
    pts_out_if.source           result
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int ENT_W = $bits(pts_entry_t);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

    logic [CNT_W-1:0]   count_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               pipe_vld_reg;
    logic [IDX_W-1:0]   wr_idx_reg;
    logic               held_vld_reg;
    logic [IDX_W-1:0]   held_idx_reg;
    logic               tick_reg;

    logic                 out_vld_reg;
    logic [IDX_OUT_W-1:0] o_idx_reg;
    logic                 o_tv_reg;
    logic                 o_st_reg;
    logic                 o_busy_reg;
    logic [CNT_OUT_W-1:0] o_cnt_reg;
    logic                 o_last_reg;

    logic                 can_load;
    logic                 found;
    logic                 stall;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [ENT_W-1:0]     rd_data;
    pts_entry_t           rd_ent;
    logic [PERIOD_W-1:0]  cd_dec;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    pts_entry_t           wr_ent;
    logic                 room;
    logic                 emit_walk;
    logic                 load;
    logic [IDX_W-1:0]     n_idx;
    logic                 n_tv;
    logic                 n_st;
    logic                 n_busy;
    logic [CNT_W-1:0]     n_cnt;
    logic                 n_last;
    logic [IDX_W+IDX_OUT_W-1:0] idx_ext;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

    pts_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_ent),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign can_load = !out_vld_reg || result.ready;
    assign rd_ent   = pts_entry_t'(rd_data);
    assign cd_dec   = rd_ent.countdown - PERIOD_W'(1);
    assign found    = pipe_vld_reg && !tick_reg && rd_ent.pend;
    assign stall    = found && held_vld_reg && !can_load;
    assign rd_en    = cmd.walk && !stall && (rd_idx_reg < count_reg);
    assign rd_addr  = rd_idx_reg[IDX_W-1:0];
    assign room     = count_reg < CNT_MAX;
    assign emit_walk = cmd.walk && !stall && found && held_vld_reg;

    assign stat.can_load  = can_load;
    assign stat.walk_done = !pipe_vld_reg && (rd_idx_reg >= count_reg);

    // slot update on write-back
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = wr_idx_reg;
        wr_ent  = rd_ent;
        if (cmd.walk && !stall && pipe_vld_reg)
        begin
            wr_en = 1'b1;
            if (tick_reg)
            begin
                if (rd_ent.countdown != '0)
                begin
                    if (cd_dec == '0)
                    begin
                        wr_ent.countdown = rd_ent.reload;
                        wr_ent.pend      = 1'b1;
                    end
                    else
                    begin
                        wr_ent.countdown = cd_dec;
                    end
                end
            end
            else
            begin
                wr_ent.pend = 1'b0;
            end
        end
        if (cmd.do_register && room)
        begin
            wr_en            = 1'b1;
            wr_addr          = count_reg[IDX_W-1:0];
            wr_ent.pend      = 1'b0;
            wr_ent.countdown = period;
            wr_ent.reload    = period;
        end
    end

    // result select
    always_comb
    begin
        load   = 1'b0;
        n_idx  = '0;
        n_tv   = 1'b0;
        n_st   = 1'b0;
        n_last = 1'b1;
        n_cnt  = count_reg;
        n_busy = delay_reg != '0;
        if (emit_walk)
        begin
            load   = 1'b1;
            n_idx  = held_idx_reg;
            n_tv   = 1'b1;
            n_last = 1'b0;
        end
        else if (cmd.finish && can_load)
        begin
            load = 1'b1;
            if (held_vld_reg)
            begin
                n_idx = held_idx_reg;
                n_tv  = 1'b1;
            end
        end
        else if (cmd.do_register)
        begin
            load = 1'b1;
            if (room)
            begin
                n_idx = count_reg[IDX_W-1:0];
                n_tv  = 1'b1;
                n_cnt = count_reg + CNT_W'(1);
            end
            else
            begin
                n_st = 1'b1;
            end
        end
        else if (cmd.load_delay)
        begin
            load   = 1'b1;
            n_busy = delay_count != '0;
        end
        idx_ext = {{IDX_OUT_W{1'b0}}, n_idx};
        cnt_ext = {{CNT_OUT_W{1'b0}}, n_cnt};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            delay_reg    <= '0;
            rd_idx_reg   <= '0;
            pipe_vld_reg <= 1'b0;
            held_vld_reg <= 1'b0;
            tick_reg     <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.do_register && room)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.load_delay)
            begin
                delay_reg <= delay_count;
            end
            else if (cmd.dec_delay && delay_reg != '0)
            begin
                delay_reg <= delay_reg - DELAY_W'(1);
            end
            if (cmd.start_walk)
            begin
                rd_idx_reg   <= '0;
                pipe_vld_reg <= 1'b0;
                held_vld_reg <= 1'b0;
                tick_reg     <= cmd.walk_tick;
            end
            else if (cmd.walk && !stall)
            begin
                if (rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + CNT_W'(1);
                end
                pipe_vld_reg <= rd_en;
                if (found)
                begin
                    held_vld_reg <= 1'b1;
                end
            end
            else if (cmd.finish && can_load)
            begin
                held_vld_reg <= 1'b0;
            end
            if (load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk && !stall)
        begin
            wr_idx_reg <= rd_addr;
            if (found)
            begin
                held_idx_reg <= wr_idx_reg;
            end
        end
        if (load)
        begin
            o_idx_reg  <= idx_ext[IDX_OUT_W-1:0];
            o_tv_reg   <= n_tv;
            o_st_reg   <= n_st;
            o_busy_reg <= n_busy;
            o_cnt_reg  <= cnt_ext[CNT_OUT_W-1:0];
            o_last_reg <= n_last;
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.task_index = o_idx_reg;
    assign result.task_valid = o_tv_reg;
    assign result.status     = o_st_reg;
    assign result.delay_busy = o_busy_reg;
    assign result.task_count = o_cnt_reg;
    assign result.last       = o_last_reg;

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("slot read and write collide");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_MAX) && (rd_idx_reg <= count_reg))
        else $error("slot count or walk index out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> can_load)
        else $error("result register overwritten while occupied");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && stall) |=> $stable(rd_data))
        else $error("slot data lost during stall");

endmodule

// ===== src/periodic_task_tick_scheduler_core.sv =====
// top level of the periodic task tick scheduler
// usage:
//   item channel carries mode, period and delay_count; a transfer happens when
//   valid and ready are both high. result channel carries task_index, task_valid,
//   status, delay_busy, task_count and last, with the same handshake.
//   register and start-delay items give one result the cycle after the transfer.
//   tick and dispatch items walk the task table one slot per cycle while the
//   receiver does not stall, through the table ram's single read port, one item
//   at a time: the next item can transfer once the final result is loaded.
//   dispatch gives one result per pending slot in slot order, last set on the
//   final one; with none pending it gives one result with task_valid low.
//   every other item gives exactly one result with last set.
//   a result sits in an output register, so ready rises for the next item as soon
//   as that register is free or being drained in the same cycle.
//   if the receiver stalls, the walk holds in place and no transfer is lost.
//   reset clears the slot count, the delay counter and all handshake state; table
//   entries are written when a slot is registered and need no clearing.
module periodic_task_tick_scheduler_core import pts_pkg::*; #(
    parameter int MAX_TASKS = MAX_TASKS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    pts_in_if.sink    item,
    pts_out_if.source result
);

    pts_cmd_t    cmd;
    pts_status_t stat;
    mode_t       item_mode;

    assign item_mode = mode_t'(item.mode);

    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_mode  (item_mode),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pts_datapath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .period      (item.period),
        .delay_count (item.delay_count),
        .result      (result)
    );

endmodule

// ===== test/tb_periodic_task_tick_scheduler_core.sv =====
// testbench for the periodic task tick scheduler checked against a local scheduler model
`timescale 1ns / 100ps

module tb_periodic_task_tick_scheduler_core import pts_pkg::*;;

    localparam int SLOTS       = MAX_TASKS_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PRINT_LIMIT = 60;

    typedef struct {
        mode_t               mode;
        logic [PERIOD_W-1:0] period;
        logic [DELAY_W-1:0]  delay_count;
        int                  phase;
        bit                  drain_first;
    } sched_item_t;

    typedef struct packed {
        logic [IDX_OUT_W-1:0] task_index;
        logic                 task_valid;
        logic                 status;
        logic                 delay_busy;
        logic [CNT_OUT_W-1:0] task_count;
        logic                 last;
    } sched_result_t;

    logic clk;
    logic rst_n;

    pts_in_if  item ();
    pts_out_if result ();

    periodic_task_tick_scheduler_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    // scheduler state as seen from outside
    logic [PERIOD_W-1:0] slot_reload [SLOTS];
    logic [PERIOD_W-1:0] slot_left [SLOTS];
    logic                slot_pending [SLOTS];
    int                  n_slots;
    logic [DELAY_W-1:0]  delay_left;

    sched_item_t   item_queue [$];
    sched_result_t results_due [$];
    sched_item_t   cur_item;
    int            cur_phase;
    int            errors;
    int            cycles;

    function automatic int send_idle_pct(int ph);
        return (ph == 0) ? 21 : (ph == 1) ? 58 : 0;
    endfunction

    function automatic int recv_idle_pct(int ph);
        return (ph == 0) ? 58 : (ph == 1) ? 21 : 0;
    endfunction

    function automatic void add_item(mode_t m, int per, int dly, int ph, bit drain);
        sched_item_t it;
        it.mode        = m;
        it.period      = per[PERIOD_W-1:0];
        it.delay_count = dly[DELAY_W-1:0];
        it.phase       = ph;
        it.drain_first = drain;
        item_queue.push_back(it);
    endfunction

    function automatic void push_result(int idx, logic vld, logic st, logic lst);
        sched_result_t r;
        r.task_index = idx[IDX_OUT_W-1:0];
        r.task_valid = vld;
        r.status     = st;
        r.delay_busy = (delay_left != '0);
        r.task_count = n_slots[CNT_OUT_W-1:0];
        r.last       = lst;
        results_due.push_back(r);
    endfunction

    function automatic void apply_scheduler_item(sched_item_t it);
        int last_slot;
        last_slot = -1;
        case (it.mode)
            MODE_TICK:
            begin
                for (int i = 0; i < n_slots; i++)
                begin
                    if (slot_left[i] != '0)
                    begin
                        slot_left[i] = slot_left[i] - 1'b1;
                        if (slot_left[i] == '0)
                        begin
                            slot_left[i]    = slot_reload[i];
                            slot_pending[i] = 1'b1;
                        end
                    end
                end
                if (delay_left != '0)
                    delay_left = delay_left - 1'b1;
                push_result(0, 1'b0, 1'b0, 1'b1);
            end
            MODE_DISPATCH:
            begin
                for (int i = 0; i < n_slots; i++)
                begin
                    if (slot_pending[i])
                        last_slot = i;
                end
                if (last_slot < 0)
                    push_result(0, 1'b0, 1'b0, 1'b1);
                else
                begin
                    for (int i = 0; i <= last_slot; i++)
                    begin
                        if (slot_pending[i])
                        begin
                            slot_pending[i] = 1'b0;
                            push_result(i, 1'b1, 1'b0, i == last_slot);
                        end
                    end
                end
            end
            MODE_REGISTER:
            begin
                if (n_slots >= SLOTS)
                    push_result(0, 1'b0, 1'b1, 1'b1);
                else
                begin
                    slot_reload[n_slots]  = it.period;
                    slot_left[n_slots]    = it.period;
                    slot_pending[n_slots] = 1'b0;
                    n_slots++;
                    push_result(n_slots - 1, 1'b1, 1'b0, 1'b1);
                end
            end
            default:
            begin
                delay_left = it.delay_count;
                push_result(0, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    always #5 clk = ~clk;

    // item driver
    always @(posedge clk)
    begin
        logic show;
        logic load;
        show = item.valid;
        load = 1'b0;
        if (rst_n)
        begin
            if (item.valid && item.ready)
            begin
                apply_scheduler_item(cur_item);
                show = 1'b0;
            end
            if (!show && item_queue.size() != 0)
            begin
                if (!(item_queue[0].drain_first && results_due.size() != 0)
                    && $urandom_range(0, 99) >= send_idle_pct(item_queue[0].phase))
                begin
                    cur_item = item_queue.pop_front();
                    show     = 1'b1;
                    load     = 1'b1;
                end
            end
            item.valid <= show;
            if (load)
            begin
                item.mode        <= cur_item.mode;
                item.period      <= cur_item.period;
                item.delay_count <= cur_item.delay_count;
                cur_phase        <= cur_item.phase;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        sched_result_t got;
        sched_result_t want;
        if (rst_n)
        begin
            if (result.valid && result.ready)
            begin
                got = {result.task_index, result.task_valid, result.status,
                       result.delay_busy, result.task_count, result.last};
                if (results_due.size() == 0)
                begin
                    errors++;
                    if (errors <= PRINT_LIMIT)
                        $display("%0t: unexpected result, expected none, %s%0d %s%b %s%b",
                                 $time, "actual idx=", got.task_index,
                                 "vld=", got.task_valid, "st=", got.status);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= PRINT_LIMIT)
                        begin
                            $display("%0t: mismatch, expected %s%0d vld=%b st=%b %s%b%s",
                                     $time, "idx=", want.task_index, want.task_valid,
                                     want.status, "busy=", want.delay_busy, "");
                            $display("%0t:           expected cnt=%0d last=%b",
                                     $time, want.task_count, want.last);
                            $display("%0t:           actual idx=%0d vld=%b st=%b busy=%b",
                                     $time, got.task_index, got.task_valid, got.status,
                                     got.delay_busy);
                            $display("%0t:           actual cnt=%0d last=%b",
                                     $time, got.task_count, got.last);
                        end
                    end
                end
            end
            result.ready <= ($urandom_range(0, 99) >= recv_idle_pct(cur_phase));
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int r;
        int per;
        int dly;
        mode_t m;
        clk              = 1'b0;
        rst_n            = 1'b0;
        item.valid       = 1'b0;
        item.mode        = MODE_TICK;
        item.period      = '0;
        item.delay_count = '0;
        result.ready     = 1'b0;
        cur_phase        = 0;
        errors           = 0;
        cycles           = 0;
        n_slots          = 0;
        delay_left       = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_reload[i]  = '0;
            slot_left[i]    = '0;
            slot_pending[i] = 1'b0;
        end

        // directed: empty table, delay extremes, period extremes, firing and dispatch
        add_item(MODE_DISPATCH, 0, 0, 0, 0);
        add_item(MODE_TICK, 255, 65535, 0, 0);
        add_item(MODE_DELAY, 0, 65535, 0, 0);
        add_item(MODE_TICK, 0, 0, 0, 0);
        add_item(MODE_DELAY, 255, 0, 0, 0);
        add_item(MODE_TICK, 0, 0, 0, 0);
        add_item(MODE_REGISTER, 1, 0, 0, 0);
        add_item(MODE_REGISTER, 0, 65535, 0, 0);
        add_item(MODE_REGISTER, 255, 0, 0, 0);
        add_item(MODE_REGISTER, 2, 0, 0, 0);
        add_item(MODE_TICK, 0, 0, 0, 0);
        add_item(MODE_TICK, 0, 0, 0, 0);
        add_item(MODE_TICK, 0, 0, 0, 0);
        add_item(MODE_DISPATCH, 255, 65535, 0, 0);
        add_item(MODE_DISPATCH, 0, 0, 0, 0);
        add_item(MODE_DELAY, 0, 1, 0, 0);
        add_item(MODE_TICK, 0, 0, 0, 0);
        add_item(MODE_TICK, 0, 0, 0, 0);
        add_item(MODE_REGISTER, 128, 0, 0, 0);
        add_item(MODE_TICK, 0, 0, 0, 0);
        add_item(MODE_DISPATCH, 0, 0, 0, 0);

        for (int ph = 0; ph < 3; ph++)
        begin
            for (int k = 0; k < 155; k++)
            begin
                r   = $urandom_range(0, 99);
                per = $urandom_range(0, 255);
                dly = $urandom_range(0, 65535);
                if (r < 45)
                    m = MODE_TICK;
                else if (r < 65)
                    m = MODE_DISPATCH;
                else if (r < 83)
                begin
                    m = MODE_REGISTER;
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        per = 0;
                    else if (r > 1)
                        per = $urandom_range(1, 6);
                end
                else
                begin
                    m = MODE_DELAY;
                    if ($urandom_range(0, 4) != 0)
                        dly = $urandom_range(0, 12);
                end
                add_item(m, per, dly, ph, k == 0 || $urandom_range(0, 49) == 0);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (item_queue.size() != 0 || item.valid || results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
